### rtl/aclint_tmr_pkg.sv
// ----------------------------------------------------------------------------
// aclint_tmr_pkg
// Shared types and constants of the machine timer register block: request and
// response transactions, controller commands, register and request codes.
// ----------------------------------------------------------------------------
package aclint_tmr_pkg;

   // number of harts with a compare register implemented
   localparam int MAX_HARTS  = 8;
   localparam int HART_IDX_W = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
   localparam logic [6:0] MAX_HARTS_HC = 7'(MAX_HARTS);

   // size of the device window in bytes
   localparam logic [15:0] WINDOW_SIZE = 16'hc000;
   localparam logic [63:0] LOW_WORD    = 64'h0000_0000_ffff_ffff;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MTIME_OFFSET    = 3'd0,
      CSR_TIMESYNC_OFFSET = 3'd1,
      CSR_COMPARE_BASE    = 3'd2,
      CSR_HART_COUNT      = 3'd3,
      CSR_BROADCAST_ADDR  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_code_type;

   typedef enum logic [3:0] {
      LEN_WORD  = 4'd4,
      LEN_DWORD = 4'd8
   } len_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] offset;
      logic [3:0]  length;
      logic [63:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic        read_hit;
      logic [63:0] read_data;
      logic        broadcast_valid;
      logic [63:0] broadcast_time;
      logic        compare_update;
      logic [5:0]  compare_hart;
      logic [63:0] compare_value;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

### rtl/aclint_tmr_ctrl.sv
// ----------------------------------------------------------------------------
// aclint_tmr_ctrl
// Transaction sequencer: captures a request, issues it to the datapath once
// the response register is free, and tracks response valid.
// ----------------------------------------------------------------------------
module aclint_tmr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output aclint_tmr_pkg::dp_cmd_type dp_cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_stall
);
   import aclint_tmr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      slot_free          = !rsp_valid_ff || !rsp_stall;
      dp_cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      dp_cmd.execute     = (state_ff == ST_EXEC) && slot_free;
      state_in           = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_cmd.execute) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = dp_cmd.execute || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted request is always followed by a busy cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without entering execute");

   // never overwrite a response that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |-> !(rsp_valid && rsp_stall))
      else $error("execute while response stalled");

   // a taken response with nothing new behind it drops valid
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !dp_cmd.execute |=> !rsp_valid)
      else $error("response repeated");

   // execute only ever follows a capture, and no capture directly follows another
   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |=> !dp_cmd.capture)
      else $error("second capture while busy");

endmodule

### rtl/aclint_tmr_dp.sv
// ----------------------------------------------------------------------------
// aclint_tmr_dp
// Datapath: configuration registers, mtime counter, mtimecmp file, address
// decode, word merge and the response register.
// ----------------------------------------------------------------------------
module aclint_tmr_dp (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_enable,
   input  logic [aclint_tmr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [63:0]                                   csr_write_data,
   input  aclint_tmr_pkg::req_item_type                  req_payload,
   input  aclint_tmr_pkg::dp_cmd_type                    dp_cmd,
   output aclint_tmr_pkg::rsp_item_type                  rsp_payload
);
   import aclint_tmr_pkg::*;

   logic [15:0]  mtime_offset_ff;
   logic [15:0]  timesync_offset_ff;
   logic [15:0]  compare_base_ff;
   logic [6:0]   hart_count_ff;
   logic [63:0]  broadcast_addr_ff;

   req_item_type req_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic [63:0]  mtime_ff, mtime_in;
   logic [63:0]  cmp_ff [MAX_HARTS];

   logic [15:0]           aligned;
   logic                  hi_word;
   logic                  act;
   logic                  is_word;
   logic [63:0]           wdata;
   logic                  hit_mtime, hit_sync, hit_cmp;
   logic [6:0]            harts_used;
   logic [15:0]           cmp_diff;
   logic [HART_IDX_W-1:0] hart_idx;
   logic [63:0]           cmp_sel;
   logic [63:0]           rd_reg;
   logic                  rd_hit;
   logic                  cmp_wr;
   logic [63:0]           cmp_wr_val;

   function automatic logic [63:0] merge_word(input logic [63:0] old_val,
                                              input logic [63:0] new_val,
                                              input logic        word,
                                              input logic        hi);
      logic [63:0] res;
      if (!word) begin
         res = new_val;
      end else if (hi) begin
         res = {new_val[31:0], old_val[31:0]};
      end else begin
         res = {old_val[63:32], new_val[31:0]};
      end
      return res;
   endfunction

   // decode
   always_comb begin
      aligned    = {req_ff.offset[15:3], 3'b000};
      hi_word    = req_ff.offset[2];
      is_word    = (req_ff.length == LEN_WORD);
      act        = (is_word || (req_ff.length == LEN_DWORD)) &&
                   (req_ff.offset < WINDOW_SIZE);
      wdata      = is_word ? (req_ff.write_data & LOW_WORD) : req_ff.write_data;
      hit_mtime  = (aligned == mtime_offset_ff);
      hit_sync   = (aligned == timesync_offset_ff);
      harts_used = (hart_count_ff > MAX_HARTS_HC) ? MAX_HARTS_HC : hart_count_ff;
      cmp_diff   = aligned - compare_base_ff;
      hit_cmp    = (aligned >= compare_base_ff) &&
                   (cmp_diff[15:3] < {6'b0, harts_used});
      hart_idx   = cmp_diff[3 +: HART_IDX_W];
      cmp_sel    = cmp_ff[hart_idx];
   end

   // execute
   always_comb begin
      mtime_in   = mtime_ff;
      cmp_wr     = 1'b0;
      cmp_wr_val = merge_word(cmp_sel, wdata, is_word, hi_word);
      rd_reg     = '0;
      rd_hit     = 1'b0;
      rsp_in     = '0;
      case (req_ff.req_type)
         REQ_TICK: begin
            mtime_in = mtime_ff + 64'd1;
         end
         REQ_READ: begin
            if (act) begin
               if (hit_mtime) begin
                  rd_reg = mtime_ff;
                  rd_hit = 1'b1;
               end else if (hit_sync) begin
                  rd_hit = 1'b1;
               end else if (hit_cmp) begin
                  rd_reg = cmp_sel;
                  rd_hit = 1'b1;
               end
            end
            if (rd_hit) begin
               rsp_in.read_hit = 1'b1;
               if (!is_word) begin
                  rsp_in.read_data = rd_reg;
               end else if (hi_word) begin
                  rsp_in.read_data = {32'h0, rd_reg[63:32]};
               end else begin
                  rsp_in.read_data = {32'h0, rd_reg[31:0]};
               end
            end
         end
         REQ_WRITE: begin
            if (act) begin
               if (hit_mtime) begin
                  mtime_in = merge_word(mtime_ff, wdata, is_word, hi_word);
                  if (broadcast_addr_ff != 64'd0) begin
                     rsp_in.broadcast_valid = 1'b1;
                     rsp_in.broadcast_time  = mtime_in;
                  end
               end else if (hit_sync) begin
                  if ((wdata[7:0] != 8'd0) && (broadcast_addr_ff != 64'd0)) begin
                     rsp_in.broadcast_valid = 1'b1;
                     rsp_in.broadcast_time  = mtime_ff;
                  end
               end else if (hit_cmp) begin
                  cmp_wr                = 1'b1;
                  rsp_in.compare_update = 1'b1;
                  rsp_in.compare_hart   = 6'(hart_idx);
                  rsp_in.compare_value  = cmp_wr_val;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtime_offset_ff    <= '0;
         timesync_offset_ff <= '0;
         compare_base_ff    <= '0;
         hart_count_ff      <= 7'd1;
         broadcast_addr_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MTIME_OFFSET:    mtime_offset_ff    <= csr_write_data[15:0];
            CSR_TIMESYNC_OFFSET: timesync_offset_ff <= csr_write_data[15:0];
            CSR_COMPARE_BASE:    compare_base_ff    <= csr_write_data[15:0];
            CSR_HART_COUNT:      hart_count_ff      <= csr_write_data[6:0];
            CSR_BROADCAST_ADDR:  broadcast_addr_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtime_ff <= '0;
         for (int i = 0; i < MAX_HARTS; i++) begin
            cmp_ff[i] <= '1;
         end
      end else if (dp_cmd.execute) begin
         mtime_ff <= mtime_in;
         if (cmp_wr) begin
            cmp_ff[hart_idx] <= cmp_wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_ff <= req_payload;
      end
      if (dp_cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   // only a tick or a write to mtime moves the counter
   a_mtime_source: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute && (req_ff.req_type != REQ_TICK) &&
      !(req_ff.req_type == REQ_WRITE && act && hit_mtime) |=> $stable(mtime_ff))
      else $error("mtime changed without tick or write");

   // a response carries at most one kind of event
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |-> $countones({rsp_in.read_hit, rsp_in.broadcast_valid,
                                     rsp_in.compare_update}) <= 1)
      else $error("response reports several events");

   // a compare update only comes from a decoded compare write
   a_cmp_write: assert property (@(posedge clock) disable iff (reset)
      rsp_in.compare_update |-> (req_ff.req_type == REQ_WRITE) && hit_cmp &&
                                !hit_mtime && !hit_sync)
      else $error("compare update without compare write");

endmodule

### rtl/aclint_timer_register_block_unit.sv
// ----------------------------------------------------------------------------
// aclint_timer_register_block_unit
// Machine timer register block: mtime counter, timesync strobe and per-hart
// mtimecmp registers behind a decoded register window, one response per
// request transaction.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_item_type (tick, read, write)
//   rsp_      out        rsp_valid / rsp_stall   rsp_item_type (read, broadcast, compare)
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// each transaction first captures the request, then decodes it, updates state
// and loads the response register
// the controller takes no new request until the current one has executed, as
// set by its capture/execute sequence; a new request is taken while a response waits
// reset is synchronous and active high; mtime clears, every mtimecmp goes to
// all ones, offsets clear, hart count is 1 and broadcasting is off
// a stalled response holds the execute step, so the request side stalls too
//
module aclint_timer_register_block_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration writes
   input  logic                                   csr_write_enable,
   input  logic [aclint_tmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                            csr_write_data,
   // request transactions
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  aclint_tmr_pkg::req_item_type           req_payload,
   // response transactions
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output aclint_tmr_pkg::rsp_item_type           rsp_payload
);
   import aclint_tmr_pkg::*;

   // commands from sequencer to datapath
   dp_cmd_type dp_cmd;

   // sequencer: capture, execute, response valid
   aclint_tmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   // datapath: registers, decode, merge and response register
   aclint_tmr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .dp_cmd           (dp_cmd),
      .rsp_payload      (rsp_payload)
   );

endmodule
